[design/skacc_pkg.sv]
// Shared types and codes of the sparse keyed accumulator.
`default_nettype none

package skacc_pkg;

	// Operation codes of an input item; the two highest codes do nothing.
	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_MUL    = 3'd2,
		OP_COMMIT = 3'd3,
		OP_READ   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Request from the sequencer to the shared arithmetic unit.
	typedef struct packed {
		logic go;
		logic mul;
		logic neg;
	} alu_req_t;

endpackage

`default_nettype wire

[design/skacc_alu.sv]
// Shared two-stage arithmetic unit: saturating add, subtract and fixed-point multiply.
`default_nettype none

module skacc_alu #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire skacc_pkg::alu_req_t req,
	input  wire logic signed [31:0] base,
	input  wire logic signed [31:0] operand,
	output logic                    done,
	output logic signed [31:0]      result,
	output logic                    sat
);
	import skacc_pkg::*;

	localparam int RSH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
	localparam logic signed [63:0] ROUND = (FRAC_BITS > 0) ? (64'sd1 <<< RSH) : 64'sd0;
	localparam logic signed [63:0] VMAX = 64'sd2147483647;
	localparam logic signed [63:0] VMIN = -64'sd2147483648;

	logic signed [63:0] prod;
	logic signed [63:0] sum;
	logic signed [63:0] acc_s1;
	logic               mul_s1;
	logic               valid_s1;
	logic signed [63:0] rnd;
	logic signed [63:0] shf;
	logic signed [31:0] clip_val;
	logic               clip_sat;
	logic signed [31:0] result_s2;
	logic               sat_s2;
	logic               valid_s2;

	// First stage: the full product, or the sum with the operand sign applied.
	assign prod = base * operand;
	assign sum  = 64'(base) + (req.neg ? -64'(operand) : 64'(operand));

	// Second stage: round to nearest, drop the fraction bits and saturate.
	assign rnd = acc_s1 + (mul_s1 ? ROUND : 64'sd0);
	assign shf = mul_s1 ? (rnd >>> FRAC_BITS) : acc_s1;

	always_comb begin
		clip_sat = 1'b0;
		clip_val = shf[31:0];
		if (shf > VMAX) begin
			clip_sat = 1'b1;
			clip_val = VMAX[31:0];
		end else if (shf < VMIN) begin
			clip_sat = 1'b1;
			clip_val = VMIN[31:0];
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.go;
			valid_s2 <= valid_s1;
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		if (req.go) begin
			acc_s1 <= req.mul ? prod : sum;
			mul_s1 <= req.mul;
		end
		if (valid_s1) begin
			result_s2 <= clip_val;
			sat_s2    <= clip_sat;
		end
	end

	assign done   = valid_s2;
	assign result = result_s2;
	assign sat    = sat_s2;

endmodule

`default_nettype wire

[design/sparse_keyed_accumulator_unit.sv]
// Sparse keyed accumulator: a key/value table with +=, -=, *= intersection, read and clear.
//
// Usage: items (op, key, value, slot) enter on the item channel and each one gives
// exactly one result (status, key_out, value_out, entry_count, saturated) on the
// result channel. A transfer happens on a rising edge with valid high and stall low.
// The block works on one item at a time; item_stall is high from the cycle after a
// transfer until the sequencer is back in its idle state.
// Each item's work is set by the linear key scan that reads one key memory entry per
// cycle and by the two-stage arithmetic unit: add, subtract, multiply of a stored key
// scan, load the value and pass the arithmetic unit; insert of a new key scans and
// passes the arithmetic unit; a miss that changes nothing only scans; commit sweeps
// every slot; read slot reads the memories; clear and unused codes go straight to the
// result.
// A finished result sits in the output register while the next item is taken; if
// the receiver still stalls when the next result is done, the sequencer waits.
// Reset empties the table at once (occupancy and keep marks are flip-flops); the key
// and value memories are not cleared and need no clearing pass.
`default_nettype none

module sparse_keyed_accumulator_unit #(
	parameter int CAPACITY  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [2:0]         op,
	input  wire logic [31:0]        key,
	input  wire logic signed [31:0] value,
	input  wire logic [5:0]         slot,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [1:0]              status,
	output logic [31:0]             key_out,
	output logic signed [31:0]      value_out,
	output logic [6:0]              entry_count,
	output logic                    saturated
);
	import skacc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SLX_W = (IDX_W > 6) ? IDX_W : 6;
	localparam int CEX_W = (CNT_W > 7) ? CNT_W : 7;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_LOAD,
		S_ALU,
		S_SWEEP,
		S_RD_ADDR,
		S_RD_DATA,
		S_DONE
	} state_t;

	state_t state_q;

	// Latched item.
	op_t                op_q;
	logic [31:0]        key_q;
	logic signed [31:0] val_q;
	logic [5:0]         slot_q;

	// Table state.
	logic [31:0]        key_mem [CAPACITY];
	logic signed [31:0] val_mem [CAPACITY];
	logic [CAPACITY-1:0] occ_q;
	logic [CAPACITY-1:0] kept_q;
	logic [CNT_W-1:0]   count_q;

	// Scan state.
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               chk_s1;
	logic [31:0]        key_rd_q;
	logic signed [31:0] val_rd_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	// Result being built and output register.
	logic [1:0]         res_status_q;
	logic [31:0]        res_key_q;
	logic signed [31:0] res_val_q;
	logic               res_sat_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [31:0]        out_key_q;
	logic signed [31:0] out_val_q;
	logic [6:0]         out_count_q;
	logic               out_sat_q;

	// Arithmetic unit interface.
	alu_req_t           alu_req;
	logic signed [31:0] alu_base;
	logic               alu_done;
	logic signed [31:0] alu_res;
	logic               alu_sat;

	logic [SLX_W-1:0]   slot_ext;
	logic [IDX_W-1:0]   slot_idx;
	logic               slot_in_range;
	logic [IDX_W-1:0]   occ_idx;
	logic               occ_bit;
	logic               kept_bit;
	logic               key_match;
	logic [IDX_W-1:0]   tgt_idx;
	logic [IDX_W-1:0]   key_addr;
	logic [IDX_W-1:0]   val_addr;
	logic               tbl_we;
	logic [CEX_W-1:0]   count_ext;
	op_t                op_in;

	assign op_in         = op_t'(op);
	assign slot_ext      = SLX_W'(slot_q);
	assign slot_idx      = slot_ext[IDX_W-1:0];
	assign slot_in_range = (32'(slot_q) < 32'(CAPACITY));
	assign count_ext     = CEX_W'(count_q);

	// Occupancy lookup: sweep index, read slot, or the scan stage.
	always_comb begin
		case (state_q)
			S_SWEEP:   occ_idx = idx_q;
			S_RD_DATA: occ_idx = slot_idx;
			default:   occ_idx = idx_s1;
		endcase
	end

	assign occ_bit   = occ_q[occ_idx];
	assign kept_bit  = kept_q[occ_idx];
	assign key_match = chk_s1 && occ_bit && (key_rd_q == key_q);
	assign tgt_idx   = hit_q ? hit_idx_q : free_idx_q;

	// Memory addresses.
	assign key_addr = (state_q == S_SCAN) ? idx_q : slot_idx;
	assign val_addr = (state_q == S_DECIDE) ? hit_idx_q : slot_idx;
	assign tbl_we   = (state_q == S_ALU) && alu_done;

	// Arithmetic requests: update of a stored entry, or insert of a new one.
	always_comb begin
		alu_req.go  = (state_q == S_LOAD) ||
		              ((state_q == S_DECIDE) && !hit_q && free_q && (op_q != OP_MUL));
		alu_req.mul = (op_q == OP_MUL);
		alu_req.neg = (op_q == OP_SUB);
		alu_base    = (state_q == S_LOAD) ? val_rd_q : 32'sd0;
	end

	skacc_alu #(
		.FRAC_BITS(FRAC_BITS)
	) u_skacc_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.base   (alu_base),
		.operand(val_q),
		.done   (alu_done),
		.result (alu_res),
		.sat    (alu_sat)
	);

	// Key memory with registered read.
	always_ff @(posedge clk) begin
		if (tbl_we && !hit_q) begin
			key_mem[tgt_idx] <= key_q;
		end
		key_rd_q <= key_mem[key_addr];
	end

	// Value memory with registered read.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			val_mem[tgt_idx] <= alu_res;
		end
		val_rd_q <= val_mem[val_addr];
	end

	// Sequencer, table flags and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ADD;
			occ_q        <= '0;
			kept_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			idx_s1       <= '0;
			chk_s1       <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			// Scan compare stage: first matching key and lowest free slot.
			if (key_match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (chk_s1 && !occ_bit && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end

			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q         <= op_in;
						key_q        <= key;
						val_q        <= value;
						slot_q       <= slot;
						res_status_q <= ST_OK;
						res_key_q    <= (op_in == OP_ADD || op_in == OP_SUB ||
						                 op_in == OP_MUL) ? key : 32'd0;
						res_val_q    <= 32'sd0;
						res_sat_q    <= 1'b0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
						chk_s1       <= 1'b0;
						idx_q        <= '0;
						case (op_in)
							OP_ADD, OP_SUB, OP_MUL: state_q <= S_SCAN;
							OP_COMMIT:              state_q <= S_SWEEP;
							OP_READ:                state_q <= S_RD_ADDR;
							OP_CLEAR: begin
								occ_q   <= '0;
								kept_q  <= '0;
								count_q <= '0;
								state_q <= S_DONE;
							end
							default:                state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					chk_s1 <= 1'b1;
					idx_s1 <= idx_q;
					if (idx_q == LAST_IDX) begin
						state_q <= S_SCAN_END;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN_END: begin
					chk_s1  <= 1'b0;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (hit_q) begin
						state_q <= S_LOAD;
					end else if (op_q == OP_MUL) begin
						state_q <= S_DONE;
					end else if (!free_q) begin
						res_status_q <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_ALU;
					end
				end
				S_LOAD: begin
					state_q <= S_ALU;
				end
				S_ALU: begin
					if (alu_done) begin
						res_val_q <= alu_res;
						res_sat_q <= alu_sat;
						if (!hit_q) begin
							occ_q[free_idx_q]  <= 1'b1;
							kept_q[free_idx_q] <= 1'b0;
							count_q            <= count_q + 1'b1;
						end else if (op_q == OP_MUL) begin
							kept_q[hit_idx_q] <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_SWEEP: begin
					// Drop entries that no multiply pass marked, and clear the marks.
					if (occ_bit && !kept_bit) begin
						occ_q[idx_q] <= 1'b0;
						count_q      <= count_q - 1'b1;
					end
					kept_q[idx_q] <= 1'b0;
					if (idx_q == LAST_IDX) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (slot_in_range && occ_bit) begin
						res_key_q <= key_rd_q;
						res_val_q <= val_rd_q;
					end else begin
						res_status_q <= ST_EMPTY;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !result_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_key_q    <= res_key_q;
						out_val_q    <= res_val_q;
						out_sat_q    <= res_sat_q;
						out_count_q  <= count_ext[6:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign status       = out_status_q;
	assign key_out      = out_key_q;
	assign value_out    = out_val_q;
	assign entry_count  = out_count_q;
	assign saturated    = out_sat_q;

endmodule

`default_nettype wire

[design/skacc_checker.sv]
// Port-level checks of the sparse keyed accumulator and their binding to the top level.
`default_nettype none

module skacc_checker #(
	parameter int CAPACITY = 64
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic [1:0]         status,
	input wire logic [31:0]        key_out,
	input wire logic signed [31:0] value_out,
	input wire logic [6:0]         entry_count,
	input wire logic               saturated
);
	import skacc_pkg::*;

	// A stalled result holds until its transfer.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(key_out) && $stable(value_out))
		else $error("stalled result changed");

	// One item at a time: the cycle after an item transfer the block is busy.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while a previous item is in work");

	// A dropped insert only happens with every slot occupied.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_FULL |-> entry_count == 7'(CAPACITY) && value_out == 0)
		else $error("table full reported with free slots");

	// An empty read returns a zero entry.
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_EMPTY |-> key_out == 0 && value_out == 0 && !saturated)
		else $error("empty slot read returned data");

endmodule

bind sparse_keyed_accumulator_unit skacc_checker #(
	.CAPACITY(CAPACITY)
) u_skacc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.status      (status),
	.key_out     (key_out),
	.value_out   (value_out),
	.entry_count (entry_count),
	.saturated   (saturated)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the sparse keyed accumulator unit.
`timescale 1ns / 100ps

module tb;
	import skacc_pkg::*;

	localparam int SLOTS = 64;
	localparam int FRAC = 16;
	localparam longint VAL_HI = 64'sd2147483647;
	localparam longint VAL_LO = -64'sd2147483648;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int TAIL_CYCLES = SLOTS + 16;

	typedef struct {
		logic [1:0]         status;
		logic [31:0]        key_out;
		logic signed [31:0] value_out;
		logic [6:0]         entry_count;
		logic               saturated;
	} outcome_t;

	// Tracks the table contents and the results still owed by the block.
	class table_tracker;
		logic [31:0]        keys [SLOTS];
		logic signed [31:0] vals [SLOTS];
		bit                 used [SLOTS];
		bit                 kept [SLOTS];
		int unsigned        fill;
		outcome_t           waiting [$];
		int                 mismatches;
		int                 checked;
		int                 full_drops;
		int                 clips;
		int                 empty_reads;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 1'b0;
				kept[i] = 1'b0;
			end
			fill = 0;
			mismatches = 0;
			checked = 0;
			full_drops = 0;
			clips = 0;
			empty_reads = 0;
		endfunction

		function logic signed [31:0] clip(input longint x, output bit hit);
			hit = 1'b0;
			if (x > VAL_HI) begin
				hit = 1'b1;
				return 32'sh7FFF_FFFF;
			end
			if (x < VAL_LO) begin
				hit = 1'b1;
				return 32'sh8000_0000;
			end
			return x[31:0];
		endfunction

		function int find_key(input logic [31:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && keys[i] == k)
					return i;
			return -1;
		endfunction

		function int find_free();
			for (int i = 0; i < SLOTS; i++)
				if (!used[i])
					return i;
			return -1;
		endfunction

		function int outstanding();
			return waiting.size();
		endfunction

		// Applies one accepted item to the table and queues the result it owes.
		function void note_item(input logic [2:0] code, input logic [31:0] k,
				input logic signed [31:0] v, input logic [5:0] s);
			outcome_t r;
			int i;
			longint operand;
			longint prod;
			bit hit;
			r.status = ST_OK;
			r.key_out = '0;
			r.value_out = '0;
			hit = 1'b0;
			case (code)
				OP_ADD, OP_SUB: begin
					operand = (code == OP_ADD) ? longint'(v) : -longint'(v);
					r.key_out = k;
					i = find_key(k);
					if (i >= 0) begin
						vals[i] = clip(longint'(vals[i]) + operand, hit);
						r.value_out = vals[i];
					end else begin
						i = find_free();
						if (i < 0) begin
							r.status = ST_FULL;
						end else begin
							keys[i] = k;
							vals[i] = clip(operand, hit);
							used[i] = 1'b1;
							kept[i] = 1'b0;
							fill++;
							r.value_out = vals[i];
						end
					end
				end
				OP_MUL: begin
					r.key_out = k;
					i = find_key(k);
					if (i >= 0) begin
						// Round to nearest with ties upward, then clip.
						prod = longint'(vals[i]) * longint'(v);
						if (FRAC > 0)
							prod += longint'(1) << (FRAC - 1);
						prod = prod >>> FRAC;
						vals[i] = clip(prod, hit);
						kept[i] = 1'b1;
						r.value_out = vals[i];
					end
				end
				OP_COMMIT: begin
					for (i = 0; i < SLOTS; i++) begin
						if (used[i] && !kept[i]) begin
							used[i] = 1'b0;
							fill--;
						end
						kept[i] = 1'b0;
					end
				end
				OP_READ: begin
					if (s < SLOTS && used[s]) begin
						r.key_out = keys[s];
						r.value_out = vals[s];
					end else begin
						r.status = ST_EMPTY;
					end
				end
				OP_CLEAR: begin
					for (i = 0; i < SLOTS; i++) begin
						used[i] = 1'b0;
						kept[i] = 1'b0;
					end
					fill = 0;
				end
				default: ;
			endcase
			r.entry_count = fill[6:0];
			r.saturated = hit;
			if (r.status == ST_FULL)
				full_drops++;
			if (r.status == ST_EMPTY)
				empty_reads++;
			if (hit)
				clips++;
			waiting.insert(waiting.size(), r);
		endfunction

		// Compares one result transfer with the oldest owed result.
		function void check_result(input logic [1:0] st, input logic [31:0] ko,
				input logic signed [31:0] vo, input logic [6:0] cnt, input logic sat);
			outcome_t w;
			checked++;
			if (waiting.size() == 0) begin
				$error("result with no item outstanding: key_out %h value_out %h", ko, vo);
				mismatches++;
				return;
			end
			w = waiting.pop_front();
			if (st !== w.status) begin
				$error("status: expected %0d, got %0d", w.status, st);
				mismatches++;
			end
			if (ko !== w.key_out) begin
				$error("key_out: expected %h, got %h", w.key_out, ko);
				mismatches++;
			end
			if (vo !== w.value_out) begin
				$error("value_out: expected %h, got %h", w.value_out, vo);
				mismatches++;
			end
			if (cnt !== w.entry_count) begin
				$error("entry_count: expected %0d, got %0d", w.entry_count, cnt);
				mismatches++;
			end
			if (sat !== w.saturated) begin
				$error("saturated: expected %0d, got %0d", w.saturated, sat);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [2:0]         op = OP_ADD;
	logic [31:0]        key = '0;
	logic signed [31:0] value = '0;
	logic [5:0]         slot = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [1:0]         status;
	logic [31:0]        key_out;
	logic signed [31:0] value_out;
	logic [6:0]         entry_count;
	logic               saturated;

	table_tracker book;
	int items_sent = 0;
	bit gaps_on = 1'b1;
	int hold_cycles_req = 0;

	sparse_keyed_accumulator_unit #(
		.CAPACITY(SLOTS),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.key(key),
		.value(value),
		.slot(slot),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.key_out(key_out),
		.value_out(value_out),
		.entry_count(entry_count),
		.saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every item transfer updates the tracked table.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			book.note_item(op, key, value, slot);
	end

	// Every result transfer is checked against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			book.check_result(status, key_out, value_out, entry_count, saturated);
	end

	// Receiver: random short and long stalls, calm stretches, and long hold-offs on request.
	initial begin
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles_req > 0) begin
				stall_left = hold_cycles_req;
				hold_cycles_req = 0;
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else if (calm_left > 0) begin
				result_stall <= 1'b0;
				calm_left--;
			end else begin
				result_stall <= 1'b0;
				case ($urandom_range(0, 19))
					0: calm_left = $urandom_range(50, 300);
					1: stall_left = $urandom_range(15, 60);
					2, 3, 4, 5: stall_left = $urandom_range(1, 4);
					default: ;
				endcase
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly small Q16.16 operands, with full-range words and the extremes mixed in.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'h0000_0001;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3: return $urandom();
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	function automatic logic [2:0] pick_accumulate_op();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return OP_ADD;
		if (r < 14)
			return OP_SUB;
		if (r < 17)
			return OP_MUL;
		return OP_READ;
	endfunction

	// Offers one item and holds it until the transfer, then idles for a random gap.
	task automatic send_item(input logic [2:0] code, input logic [31:0] k,
			input logic [31:0] v, input logic [5:0] s);
		int gap;
		item_valid <= 1'b1;
		op <= code;
		key <= k;
		value <= v;
		slot <= s;
		do
			@(posedge clk);
		while (item_stall);
		items_sent++;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering items until every owed result has come back.
	task automatic drain_results();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (book.outstanding() != 0);
	endtask

	initial begin
		int kind;
		int n;
		int psz;
		int fills;
		bit held;
		bit paused;
		bit first;
		logic [31:0] base;
		logic [31:0] fbase;

		book = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, clipping in both directions, rounding ties, holes.
		send_item(OP_READ, 32'h0, 32'h0, 6'd0);
		send_item(OP_ADD, 32'h0, 32'h7FFF_FFFF, 6'd0);
		send_item(OP_ADD, 32'h0, 32'h0000_0001, 6'd63);
		send_item(OP_SUB, 32'hFFFF_FFFF, 32'h8000_0000, 6'd0);
		send_item(OP_SUB, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 6'd0);
		send_item(OP_ADD, 32'h5, 32'h8000_0000, 6'd0);
		send_item(OP_SUB, 32'h5, 32'h0000_0001, 6'd0);
		send_item(OP_ADD, 32'h9, 32'h0000_0001, 6'd0);
		send_item(OP_ADD, 32'hA, 32'hFFFF_FFFF, 6'd0);
		send_item(OP_MUL, 32'h9, 32'h0000_8000, 6'd0);
		send_item(OP_MUL, 32'hA, 32'h0000_8000, 6'd0);
		send_item(OP_MUL, 32'h0, 32'h0001_0000, 6'd0);
		send_item(OP_MUL, 32'h5, 32'h7FFF_FFFF, 6'd0);
		send_item(OP_MUL, 32'h7B, 32'h0002_0000, 6'd0);
		send_item(OP_COMMIT, 32'h0, 32'h0, 6'd0);
		send_item(OP_READ, 32'h0, 32'h0, 6'd1);
		send_item(OP_READ, 32'h0, 32'h0, 6'd0);
		send_item(OP_READ, 32'h0, 32'h0, 6'd63);
		send_item(OP_ADD, 32'hAAAA_5555, 32'h0001_8000, 6'd0);
		send_item(OP_READ, 32'h0, 32'h0, 6'd1);
		send_item(OP_SPARE_LO, 32'h1234_5678, 32'h0001_0000, 6'd2);
		send_item(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_CLEAR, 32'h0, 32'h0, 6'd0);
		send_item(OP_READ, 32'h0, 32'h0, 6'd0);

		// Random part: sequences over small key pools, table fills, intersections, noise.
		base = $urandom();
		psz = 8;
		fills = 0;
		held = 1'b0;
		paused = 1'b0;
		first = 1'b1;
		while (items_sent < 890) begin
			kind = first ? 12 : $urandom_range(0, 19);
			first = 1'b0;
			gaps_on = ($urandom_range(0, 3) != 0);

			// Long receiver hold-off while items keep coming, so the input side stalls.
			if (!held && items_sent > 350) begin
				held = 1'b1;
				hold_cycles_req = 400;
				gaps_on = 1'b0;
				repeat (6)
					send_item(OP_ADD, base + $urandom_range(0, psz - 1), pick_value(),
						6'($urandom_range(0, 63)));
				gaps_on = 1'b1;
			end
			if (!paused && items_sent > 650) begin
				paused = 1'b1;
				drain_results();
			end

			if (kind == 12 && fills < 3) begin
				// Fill the table past capacity so that inserts get dropped.
				fills++;
				if ($urandom_range(0, 1))
					send_item(OP_CLEAR, $urandom(), $urandom(), 6'($urandom_range(0, 63)));
				fbase = $urandom();
				for (int i = 0; i < 70; i++)
					send_item(OP_ADD, fbase + i, pick_value(), 6'($urandom_range(0, 63)));
				send_item(OP_SUB, fbase + 100, pick_value(), 6'($urandom_range(0, 63)));
				send_item(OP_READ, $urandom(), $urandom(), 6'($urandom_range(0, 63)));
				send_item(OP_READ, $urandom(), $urandom(), 6'd63);
				base = fbase;
				psz = 70;
			end else if (kind >= 9 && kind <= 11) begin
				// Multiply pass over part of the pool, then commit the intersection.
				n = $urandom_range(1, psz);
				repeat (n)
					send_item(OP_MUL, base + $urandom_range(0, psz - 1), pick_value(),
						6'($urandom_range(0, 63)));
				send_item(OP_COMMIT, $urandom(), $urandom(), 6'($urandom_range(0, 63)));
				repeat (3)
					send_item(OP_READ, $urandom(), $urandom(), 6'($urandom_range(0, 7)));
			end else if (kind == 13) begin
				send_item(OP_CLEAR, $urandom(), $urandom(), 6'($urandom_range(0, 63)));
			end else if (kind == 14 || kind == 15) begin
				repeat (8)
					send_item(OP_READ, $urandom(), $urandom(), 6'($urandom_range(0, 63)));
			end else if (kind >= 16) begin
				n = $urandom_range(3, 10);
				repeat (n)
					send_item(3'($urandom_range(0, 7)), $urandom(), $urandom(),
						6'($urandom_range(0, 63)));
			end else begin
				// Accumulate burst on a small pool of keys.
				if ($urandom_range(0, 2) == 0) begin
					base = $urandom();
					psz = $urandom_range(2, 12);
				end
				n = $urandom_range(8, 30);
				repeat (n)
					send_item(pick_accumulate_op(), base + $urandom_range(0, psz - 1),
						pick_value(), 6'($urandom_range(0, 63)));
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.outstanding() != 0) begin
			$error("%0d results never arrived", book.outstanding());
			book.mismatches++;
		end

		$display("Coverage: %0d items sent, %0d results checked, %0d inserts dropped on a full table,",
			items_sent, book.checked, book.full_drops);
		$display("Coverage: %0d clipped updates, %0d reads of empty slots, %0d table fills.",
			book.clips, book.empty_reads, fills);
		if (book.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10ms;
		$display("tb: failure");
		$finish;
	end

endmodule
